/* hdl/mlfq_pkg.sv */
// Shared types and codes of the multilevel feedback queue scheduler.
`timescale 1ns / 1ps

package mlfq_pkg;

    localparam int LEVEL_W = 2;
    localparam int EVENT_W = 3;
    localparam int WAIT_W  = 10;
    localparam int ORDER_W = 16;
    localparam int QUANT_W = 6;

    // Request codes
    localparam logic [2:0] F_CREATE  = 3'd0;
    localparam logic [2:0] F_WAIT_EV = 3'd1;
    localparam logic [2:0] F_SET_EV  = 3'd2;
    localparam logic [2:0] F_WAIT_TK = 3'd3;
    localparam logic [2:0] F_TICK    = 3'd4;
    localparam logic [2:0] F_CANCEL  = 3'd5;
    localparam logic [2:0] F_TEST    = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SLOT  = 2'd1;
    localparam logic [1:0] ST_NO_RUN   = 2'd2;
    localparam logic [1:0] ST_NO_MATCH = 2'd3;

    // Thread states held in the slot table
    localparam logic [1:0] TS_READY   = 2'd0;
    localparam logic [1:0] TS_EVENT   = 2'd1;
    localparam logic [1:0] TS_TIMED   = 2'd2;
    localparam logic [1:0] TS_RUNNING = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] R_QHIGH = 2'd0;
    localparam logic [1:0] R_QMID  = 2'd1;
    localparam logic [1:0] R_QLOW  = 2'd2;

    typedef struct packed {
        logic [1:0]         status;
        logic [LEVEL_W-1:0] level;
        logic [EVENT_W-1:0] wait_event;
        logic [WAIT_W-1:0]  wait_left;
        logic               defer_cancel;
        logic               cancel_pending;
        logic [ORDER_W-1:0] order;
    } slot_rec_t;

    localparam int REC_W = $bits(slot_rec_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MOD,
        S_SCAN,
        S_PICKED,
        S_DISPATCH,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        SM_EVENT,
        SM_TICK,
        SM_DUE,
        SM_READY
    } scan_mode_t;

endpackage

/* hdl/mlfq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/mlfq_thread_scheduler_core.sv */
// Top level of the multilevel feedback queue scheduler.
`timescale 1ns / 1ps

// Three-level feedback scheduler over THREAD_SLOTS thread slots. A request is
// taken when start is high and busy is low; its result appears on the result
// ports with done high for one cycle and cannot be held off. Thread records
// live in a slot table memory with one read port, so every search walks the
// table one slot a cycle. Create adds a dispatch pass when idle; wait, cancel
// and test cancel add a dispatch pass when no thread runs afterwards; set event
// takes one pass, plus a dispatch pass when idle. A tick takes (k+2) passes
// when k timed waits expire on it, plus a dispatch pass when idle or when the
// quantum runs out.

module mlfq_thread_scheduler_core
    import mlfq_pkg::*;
#(
    parameter int THREAD_SLOTS = 16,
    parameter int EVENT_COUNT  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [3:0]  thread_slot,
    input  logic [1:0]  base_level,
    input  logic        cancel_deferred,
    input  logic [2:0]  event_num,
    input  logic [9:0]  wait_ticks,
    output logic        done,
    output logic [1:0]  status,
    output logic        result_valid,
    output logic [3:0]  result_slot,
    output logic        switched,
    output logic        running_valid,
    output logic [3:0]  running_slot,
    output logic [1:0]  running_level,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(THREAD_SLOTS);
    localparam int SW = $clog2(THREAD_SLOTS + 1);

    state_t     state_reg, state_next;
    scan_mode_t scan_mode_reg, scan_mode_next;

    logic [2:0]         func_reg, func_next;
    logic [3:0]         tslot_reg, tslot_next;
    logic [1:0]         blevel_reg, blevel_next;
    logic               defer_reg, defer_next;
    logic [EVENT_W-1:0] ev_reg, ev_next;
    logic [WAIT_W-1:0]  wticks_reg, wticks_next;
    logic               was_valid_reg, was_valid_next;
    logic [IW-1:0]      was_slot_reg, was_slot_next;
    logic [1:0]         stat_reg, stat_next;
    logic               rvalid_reg, rvalid_next;
    logic [IW-1:0]      rslot_reg, rslot_next;

    logic [THREAD_SLOTS-1:0] used_reg, used_next;
    logic [THREAD_SLOTS-1:0] due_reg, due_next;
    logic [ORDER_W-1:0]      counter_reg, counter_next;
    logic                    run_valid_reg, run_valid_next;
    logic [IW-1:0]           run_slot_reg, run_slot_next;
    logic [LEVEL_W-1:0]      run_level_reg, run_level_next;
    logic [QUANT_W-1:0]      qleft_reg, qleft_next;
    logic [QUANT_W-1:0]      qhigh_reg, qmid_reg, qlow_reg;

    logic [SW-1:0]      scan_idx_reg, scan_idx_next;
    logic               pipe_vld_reg, pipe_vld_next;
    logic [IW-1:0]      pipe_idx_reg, pipe_idx_next;
    logic               best_found_reg, best_found_next;
    logic [IW-1:0]      best_slot_reg, best_slot_next;
    logic [LEVEL_W-1:0] best_lvl_reg, best_lvl_next;
    logic [ORDER_W-1:0] best_age_reg, best_age_next;
    slot_rec_t          best_rec_reg, best_rec_next;

    logic        done_reg;
    logic [1:0]  out_status_reg;
    logic        out_rvalid_reg;
    logic [3:0]  out_rslot_reg;
    logic        out_switched_reg;
    logic        out_run_valid_reg;
    logic [3:0]  out_run_slot_reg;
    logic [1:0]  out_run_level_reg;

    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    slot_rec_t     ram_wdata, rec_rd;
    logic [REC_W-1:0] ram_rdata;

    logic          free_found;
    logic [IW-1:0] free_slot;
    logic [6:0]    tslot_wide;
    logic [IW-1:0] taddr;
    logic          tslot_ok;
    logic          ev_ok;

    logic               cand, better;
    logic [ORDER_W-1:0] cand_age;
    slot_rec_t          wrec;
    logic [QUANT_W-1:0] quantum_sel;
    logic               cfg_wr;

    mlfq_ram #(
        .WIDTH (REC_W),
        .DEPTH (THREAD_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rec_rd = slot_rec_t'(ram_rdata);

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            R_QHIGH: prdata = 32'(qhigh_reg);
            R_QMID:  prdata = 32'(qmid_reg);
            R_QLOW:  prdata = 32'(qlow_reg);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qhigh_reg <= QUANT_W'(10);
            qmid_reg  <= QUANT_W'(20);
            qlow_reg  <= QUANT_W'(30);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                R_QHIGH: qhigh_reg <= pwdata[QUANT_W-1:0];
                R_QMID:  qmid_reg  <= pwdata[QUANT_W-1:0];
                R_QLOW:  qlow_reg  <= pwdata[QUANT_W-1:0];
                default: ;
            endcase
        end
    end

    // Lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = THREAD_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = IW'(i);
            end
        end
    end

    assign tslot_wide = 7'(tslot_reg);
    assign taddr      = tslot_wide[IW-1:0];
    assign tslot_ok   = tslot_wide < 7'(THREAD_SLOTS);
    assign ev_ok      = 6'(ev_reg) < 6'(EVENT_COUNT);

    always_comb
    begin
        state_next      = state_reg;
        scan_mode_next  = scan_mode_reg;
        func_next       = func_reg;
        tslot_next      = tslot_reg;
        blevel_next     = blevel_reg;
        defer_next      = defer_reg;
        ev_next         = ev_reg;
        wticks_next     = wticks_reg;
        was_valid_next  = was_valid_reg;
        was_slot_next   = was_slot_reg;
        stat_next       = stat_reg;
        rvalid_next     = rvalid_reg;
        rslot_next      = rslot_reg;
        used_next       = used_reg;
        due_next        = due_reg;
        counter_next    = counter_reg;
        run_valid_next  = run_valid_reg;
        run_slot_next   = run_slot_reg;
        run_level_next  = run_level_reg;
        qleft_next      = qleft_reg;
        scan_idx_next   = scan_idx_reg;
        pipe_vld_next   = 1'b0;
        pipe_idx_next   = pipe_idx_reg;
        best_found_next = best_found_reg;
        best_slot_next  = best_slot_reg;
        best_lvl_next   = best_lvl_reg;
        best_age_next   = best_age_reg;
        best_rec_next   = best_rec_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = rec_rd;
        ram_raddr       = '0;
        cand            = 1'b0;
        better          = 1'b0;
        cand_age        = counter_reg - rec_rd.order;
        wrec            = rec_rd;
        quantum_sel     = qlow_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next      = func;
                    tslot_next     = thread_slot;
                    blevel_next    = base_level;
                    defer_next     = cancel_deferred;
                    ev_next        = event_num;
                    wticks_next    = wait_ticks;
                    was_valid_next = run_valid_reg;
                    was_slot_next  = run_slot_reg;
                    stat_next      = ST_OK;
                    rvalid_next    = 1'b0;
                    rslot_next     = '0;
                    state_next     = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next      = S_DISPATCH;
                scan_idx_next   = '0;
                best_found_next = 1'b0;
                unique case (func_reg) inside
                    F_CREATE:
                    begin
                        if (free_found)
                        begin
                            wrec.status         = TS_READY;
                            wrec.level          = (blevel_reg > 2'd2) ? 2'd2 : blevel_reg;
                            wrec.wait_event     = '0;
                            wrec.wait_left      = '0;
                            wrec.defer_cancel   = defer_reg;
                            wrec.cancel_pending = 1'b0;
                            wrec.order          = counter_reg;
                            ram_we              = 1'b1;
                            ram_waddr           = free_slot;
                            ram_wdata           = wrec;
                            used_next[free_slot] = 1'b1;
                            counter_next        = counter_reg + 1'b1;
                            rvalid_next         = 1'b1;
                            rslot_next          = free_slot;
                        end
                        else
                        begin
                            stat_next = ST_NO_SLOT;
                        end
                    end
                    F_WAIT_EV:
                    begin
                        if (!run_valid_reg)
                        begin
                            stat_next = ST_NO_RUN;
                        end
                        else if (!ev_ok)
                        begin
                            stat_next = ST_NO_MATCH;
                        end
                        else
                        begin
                            ram_raddr  = run_slot_reg;
                            state_next = S_MOD;
                        end
                    end
                    F_SET_EV:
                    begin
                        if (!ev_ok)
                        begin
                            stat_next = ST_NO_MATCH;
                        end
                        else
                        begin
                            scan_mode_next = SM_EVENT;
                            state_next     = S_SCAN;
                        end
                    end
                    F_WAIT_TK, F_TEST:
                    begin
                        if (!run_valid_reg)
                        begin
                            stat_next = ST_NO_RUN;
                        end
                        else
                        begin
                            ram_raddr  = run_slot_reg;
                            state_next = S_MOD;
                        end
                    end
                    F_TICK:
                    begin
                        due_next       = '0;
                        scan_mode_next = SM_TICK;
                        state_next     = S_SCAN;
                    end
                    F_CANCEL:
                    begin
                        if (!tslot_ok || !used_reg[taddr])
                        begin
                            stat_next = ST_NO_MATCH;
                        end
                        else
                        begin
                            ram_raddr  = taddr;
                            state_next = S_MOD;
                        end
                    end
                    default:
                    begin
                        stat_next = ST_NO_MATCH;
                    end
                endcase
            end

            S_MOD:
            begin
                state_next = S_DISPATCH;
                case (func_reg)
                    F_WAIT_EV:
                    begin
                        wrec.status     = TS_EVENT;
                        wrec.wait_event = ev_reg;
                        wrec.order      = counter_reg;
                        ram_we          = 1'b1;
                        ram_waddr       = run_slot_reg;
                        ram_wdata       = wrec;
                        counter_next    = counter_reg + 1'b1;
                        run_valid_next  = 1'b0;
                    end
                    F_WAIT_TK:
                    begin
                        wrec.status    = TS_TIMED;
                        wrec.wait_left = wticks_reg;
                        wrec.order     = counter_reg;
                        ram_we         = 1'b1;
                        ram_waddr      = run_slot_reg;
                        ram_wdata      = wrec;
                        counter_next   = counter_reg + 1'b1;
                        run_valid_next = 1'b0;
                    end
                    F_TICK:
                    begin
                        if (qleft_reg <= QUANT_W'(1))
                        begin
                            // quantum spent: demote and requeue
                            if (wrec.level < 2'd2)
                            begin
                                wrec.level = wrec.level + 1'b1;
                            end
                            wrec.status    = TS_READY;
                            wrec.order     = counter_reg;
                            ram_we         = 1'b1;
                            ram_waddr      = run_slot_reg;
                            ram_wdata      = wrec;
                            counter_next   = counter_reg + 1'b1;
                            run_valid_next = 1'b0;
                        end
                        else
                        begin
                            qleft_next = qleft_reg - 1'b1;
                        end
                    end
                    F_CANCEL:
                    begin
                        if (rec_rd.defer_cancel)
                        begin
                            wrec.cancel_pending = 1'b1;
                            ram_we              = 1'b1;
                            ram_waddr           = taddr;
                            ram_wdata           = wrec;
                        end
                        else
                        begin
                            used_next[taddr] = 1'b0;
                            if (run_valid_reg && run_slot_reg == taddr)
                            begin
                                run_valid_next = 1'b0;
                            end
                        end
                    end
                    F_TEST:
                    begin
                        if (rec_rd.cancel_pending)
                        begin
                            used_next[run_slot_reg] = 1'b0;
                            run_valid_next          = 1'b0;
                        end
                        else
                        begin
                            stat_next = ST_NO_MATCH;
                        end
                    end
                    default: ;
                endcase
            end

            S_SCAN:
            begin
                // issue one read a cycle, judge the slot read in the cycle before
                if (scan_idx_reg < SW'(THREAD_SLOTS))
                begin
                    ram_raddr     = scan_idx_reg[IW-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = scan_idx_reg[IW-1:0];
                end
                if (pipe_vld_reg)
                begin
                    case (scan_mode_reg)
                        SM_EVENT:
                            cand = used_reg[pipe_idx_reg] && rec_rd.status == TS_EVENT
                                   && rec_rd.wait_event == ev_reg;
                        SM_DUE:
                            cand = used_reg[pipe_idx_reg] && rec_rd.status == TS_TIMED
                                   && due_reg[pipe_idx_reg];
                        SM_READY:
                            cand = used_reg[pipe_idx_reg] && rec_rd.status == TS_READY;
                        default:
                            cand = 1'b0;
                    endcase
                    if (scan_mode_reg == SM_DUE)
                    begin
                        better = !best_found_reg || cand_age > best_age_reg;
                    end
                    else
                    begin
                        better = !best_found_reg || rec_rd.level < best_lvl_reg
                                 || (rec_rd.level == best_lvl_reg
                                     && cand_age > best_age_reg);
                    end
                    if (cand && better)
                    begin
                        best_found_next = 1'b1;
                        best_slot_next  = pipe_idx_reg;
                        best_lvl_next   = rec_rd.level;
                        best_age_next   = cand_age;
                        best_rec_next   = rec_rd;
                    end
                    if (scan_mode_reg == SM_TICK && used_reg[pipe_idx_reg]
                        && rec_rd.status == TS_TIMED)
                    begin
                        if (rec_rd.wait_left <= WAIT_W'(1))
                        begin
                            due_next[pipe_idx_reg] = 1'b1;
                        end
                        else
                        begin
                            wrec.wait_left = rec_rd.wait_left - 1'b1;
                            ram_we         = 1'b1;
                            ram_waddr      = pipe_idx_reg;
                            ram_wdata      = wrec;
                        end
                    end
                    if (scan_idx_reg == SW'(THREAD_SLOTS))
                    begin
                        state_next = S_PICKED;
                    end
                end
            end

            S_PICKED:
            begin
                wrec = best_rec_reg;
                if (wrec.level > 2'd0)
                begin
                    wrec.level = wrec.level - 1'b1;
                end
                wrec.status     = TS_READY;
                wrec.order      = counter_reg;
                ram_waddr       = best_slot_reg;
                ram_wdata       = wrec;
                scan_idx_next   = '0;
                best_found_next = 1'b0;
                state_next      = S_DISPATCH;
                case (scan_mode_reg)
                    SM_EVENT:
                    begin
                        if (best_found_reg)
                        begin
                            ram_we       = 1'b1;
                            counter_next = counter_reg + 1'b1;
                            rvalid_next  = 1'b1;
                            rslot_next   = best_slot_reg;
                        end
                        else
                        begin
                            stat_next = ST_NO_MATCH;
                        end
                    end
                    SM_TICK:
                    begin
                        scan_mode_next = SM_DUE;
                        state_next     = S_SCAN;
                    end
                    SM_DUE:
                    begin
                        if (best_found_reg)
                        begin
                            // promote the oldest expired waiter, then look again
                            ram_we                  = 1'b1;
                            counter_next            = counter_reg + 1'b1;
                            due_next[best_slot_reg] = 1'b0;
                            state_next              = S_SCAN;
                        end
                        else if (run_valid_reg)
                        begin
                            ram_raddr  = run_slot_reg;
                            state_next = S_MOD;
                        end
                    end
                    default:
                    begin
                        if (best_found_reg)
                        begin
                            case (best_lvl_reg)
                                2'd0:    quantum_sel = qhigh_reg;
                                2'd1:    quantum_sel = qmid_reg;
                                default: quantum_sel = qlow_reg;
                            endcase
                            wrec           = best_rec_reg;
                            wrec.status    = TS_RUNNING;
                            ram_wdata      = wrec;
                            ram_we         = 1'b1;
                            run_valid_next = 1'b1;
                            run_slot_next  = best_slot_reg;
                            run_level_next = best_lvl_reg;
                            qleft_next     = quantum_sel;
                        end
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_DISPATCH:
            begin
                scan_idx_next   = '0;
                best_found_next = 1'b0;
                if (!run_valid_reg)
                begin
                    scan_mode_next = SM_READY;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            counter_reg    <= '0;
            run_valid_reg  <= 1'b0;
            run_slot_reg   <= '0;
            qleft_reg      <= '0;
            pipe_vld_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            counter_reg   <= counter_next;
            run_valid_reg <= run_valid_next;
            run_slot_reg  <= run_slot_next;
            qleft_reg     <= qleft_next;
            pipe_vld_reg  <= pipe_vld_next;
            done_reg      <= (state_reg == S_FINISH);
        end
    end

    always_ff @(posedge clk)
    begin
        scan_mode_reg  <= scan_mode_next;
        func_reg       <= func_next;
        tslot_reg      <= tslot_next;
        blevel_reg     <= blevel_next;
        defer_reg      <= defer_next;
        ev_reg         <= ev_next;
        wticks_reg     <= wticks_next;
        was_valid_reg  <= was_valid_next;
        was_slot_reg   <= was_slot_next;
        stat_reg       <= stat_next;
        rvalid_reg     <= rvalid_next;
        rslot_reg      <= rslot_next;
        due_reg        <= due_next;
        run_level_reg  <= run_level_next;
        scan_idx_reg   <= scan_idx_next;
        pipe_idx_reg   <= pipe_idx_next;
        best_found_reg <= best_found_next;
        best_slot_reg  <= best_slot_next;
        best_lvl_reg   <= best_lvl_next;
        best_age_reg   <= best_age_next;
        best_rec_reg   <= best_rec_next;
        if (state_reg == S_FINISH)
        begin
            out_status_reg    <= stat_reg;
            out_rvalid_reg    <= rvalid_reg;
            out_rslot_reg     <= rvalid_reg ? 4'(rslot_reg) : 4'd0;
            out_switched_reg  <= (was_valid_reg != run_valid_reg)
                                 || (was_valid_reg && run_valid_reg
                                     && was_slot_reg != run_slot_reg);
            out_run_valid_reg <= run_valid_reg;
            out_run_slot_reg  <= run_valid_reg ? 4'(run_slot_reg) : 4'd0;
            out_run_level_reg <= run_valid_reg ? run_level_reg : 2'd0;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = out_status_reg;
    assign result_valid  = out_rvalid_reg;
    assign result_slot   = out_rslot_reg;
    assign switched      = out_switched_reg;
    assign running_valid = out_run_valid_reg;
    assign running_slot  = out_run_slot_reg;
    assign running_level = out_run_level_reg;

endmodule

/* tb/sv/mlfq_thread_scheduler_core_tb.sv */
// Self-checking testbench of the three-level feedback scheduler core.
`timescale 1ns / 1ps

module mlfq_thread_scheduler_core_tb;
    import mlfq_pkg::*;

    localparam int          SLOTS     = 16;
    localparam logic [2:0]  F_UNUSED  = 3'd7;
    localparam longint      LIMIT     = 3000000;

    typedef struct {
        logic [2:0] func;
        logic [3:0] tslot;
        logic [1:0] blevel;
        logic       defer;
        logic [2:0] ev;
        logic [9:0] wticks;
    } sched_req_t;

    typedef struct {
        logic [1:0] status;
        logic       rvalid;
        logic [3:0] rslot;
        logic       sw;
        logic       run_valid;
        logic [3:0] run_slot;
        logic [1:0] run_level;
    } sched_outcome_t;

    class mlfq_scoreboard;
        sched_outcome_t pending_outcomes[$];
        int             errors;
        logic [5:0]     quantum[3];
        logic           used[SLOTS];
        logic [1:0]     tstate[SLOTS];
        logic [1:0]     level[SLOTS];
        logic [2:0]     ev_of[SLOTS];
        logic [9:0]     wait_left[SLOTS];
        logic           cmode[SLOTS];
        logic           cpend[SLOTS];
        logic [15:0]    order[SLOTS];
        logic           due[SLOTS];
        logic [15:0]    order_cnt;
        logic           running;
        logic [3:0]     cur;
        logic [5:0]     qleft;

        function new();
            quantum[0] = 6'd10; quantum[1] = 6'd20; quantum[2] = 6'd30;
            foreach (used[s]) used[s] = 1'b0;
            order_cnt = '0; running = 1'b0; cur = '0; qleft = '0;
            errors = 0;
        endfunction

        function void stamp(int s);
            order[s] = order_cnt;
            order_cnt = order_cnt + 16'd1;
        endfunction

        function logic [15:0] age(int s);
            return order_cnt - order[s];
        endfunction

        // Highest level first, then oldest; ev < 0 matches any event
        function int pick_best(logic [1:0] st, int ev);
            int best;
            best = -1;
            for (int s = 0; s < SLOTS; s++) begin
                if (!used[s] || tstate[s] != st) continue;
                if (ev >= 0 && ev_of[s] != ev[2:0]) continue;
                if (best < 0 || level[s] < level[best] ||
                    (level[s] == level[best] && age(s) > age(best)))
                    best = s;
            end
            return best;
        endfunction

        function void promote(int s);
            if (level[s] > 0) level[s] = level[s] - 2'd1;
            tstate[s] = TS_READY;
            stamp(s);
        endfunction

        function void note_request(sched_req_t r);
            sched_outcome_t o;
            logic           was_valid;
            logic [3:0]     was_slot;
            int             f, w, d;
            o = '{default: '0};
            was_valid = running;
            was_slot = cur;
            case (r.func)
                F_CREATE: begin
                    f = -1;
                    for (int s = 0; s < SLOTS; s++)
                        if (!used[s] && f < 0) f = s;
                    if (f < 0) o.status = ST_NO_SLOT;
                    else begin
                        used[f] = 1'b1;
                        tstate[f] = TS_READY;
                        level[f] = (r.blevel > 2) ? 2'd2 : r.blevel;
                        ev_of[f] = '0;
                        wait_left[f] = '0;
                        cmode[f] = r.defer;
                        cpend[f] = 1'b0;
                        stamp(f);
                        o.rvalid = 1'b1;
                        o.rslot = f[3:0];
                    end
                end
                F_WAIT_EV: begin
                    if (!running) o.status = ST_NO_RUN;
                    else begin
                        tstate[cur] = TS_EVENT;
                        ev_of[cur] = r.ev;
                        stamp(cur);
                        running = 1'b0;
                    end
                end
                F_SET_EV: begin
                    w = pick_best(TS_EVENT, int'(r.ev));
                    if (w < 0) o.status = ST_NO_MATCH;
                    else begin
                        promote(w);
                        o.rvalid = 1'b1;
                        o.rslot = w[3:0];
                    end
                end
                F_WAIT_TK: begin
                    if (!running) o.status = ST_NO_RUN;
                    else begin
                        tstate[cur] = TS_TIMED;
                        wait_left[cur] = r.wticks;
                        stamp(cur);
                        running = 1'b0;
                    end
                end
                F_TICK: begin
                    for (int s = 0; s < SLOTS; s++) begin
                        due[s] = 1'b0;
                        if (!used[s] || tstate[s] != TS_TIMED) continue;
                        if (wait_left[s] <= 1) due[s] = 1'b1;
                        else wait_left[s] = wait_left[s] - 10'd1;
                    end
                    // Release expired sleepers oldest first; each stamp shifts the ages
                    forever begin
                        w = -1;
                        for (int s = 0; s < SLOTS; s++) begin
                            if (!used[s] || tstate[s] != TS_TIMED || !due[s]) continue;
                            if (w < 0 || age(s) > age(w)) w = s;
                        end
                        if (w < 0) break;
                        due[w] = 1'b0;
                        promote(w);
                    end
                    if (running) begin
                        if (qleft <= 1) begin
                            if (level[cur] < 2) level[cur] = level[cur] + 2'd1;
                            tstate[cur] = TS_READY;
                            stamp(cur);
                            running = 1'b0;
                        end else qleft = qleft - 6'd1;
                    end
                end
                F_CANCEL: begin
                    if (!used[r.tslot]) o.status = ST_NO_MATCH;
                    else if (cmode[r.tslot]) cpend[r.tslot] = 1'b1;
                    else begin
                        used[r.tslot] = 1'b0;
                        if (running && cur == r.tslot) running = 1'b0;
                    end
                end
                F_TEST: begin
                    if (!running) o.status = ST_NO_RUN;
                    else if (!cpend[cur]) o.status = ST_NO_MATCH;
                    else begin
                        used[cur] = 1'b0;
                        running = 1'b0;
                    end
                end
                default: o.status = ST_NO_MATCH;
            endcase
            if (!running) begin
                d = pick_best(TS_READY, -1);
                if (d >= 0) begin
                    tstate[d] = TS_RUNNING;
                    running = 1'b1;
                    cur = d[3:0];
                    qleft = quantum[level[d]];
                end
            end
            o.sw = (was_valid != running) || (was_valid && running && was_slot != cur);
            o.run_valid = running;
            o.run_slot = running ? cur : 4'd0;
            o.run_level = running ? level[cur] : 2'd0;
            pending_outcomes.push_back(o);
        endfunction

        task report(string what, logic [3:0] got, logic [3:0] want);
            $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(sched_outcome_t g);
            sched_outcome_t e;
            if (pending_outcomes.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                errors++;
                return;
            end
            e = pending_outcomes.pop_front();
            if (g.status !== e.status) report("status", g.status, e.status);
            if (g.rvalid !== e.rvalid) report("result_valid", g.rvalid, e.rvalid);
            if (g.rslot !== e.rslot) report("result_slot", g.rslot, e.rslot);
            if (g.sw !== e.sw) report("switched", g.sw, e.sw);
            if (g.run_valid !== e.run_valid) report("running_valid", g.run_valid, e.run_valid);
            if (g.run_slot !== e.run_slot) report("running_slot", g.run_slot, e.run_slot);
            if (g.run_level !== e.run_level) report("running_level", g.run_level, e.run_level);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  func = '0;
    logic [3:0]  thread_slot = '0;
    logic [1:0]  base_level = '0;
    logic        cancel_deferred = 1'b0;
    logic [2:0]  event_num = '0;
    logic [9:0]  wait_ticks = '0;
    logic        done;
    logic [1:0]  status;
    logic        result_valid;
    logic [3:0]  result_slot;
    logic        switched;
    logic        running_valid;
    logic [3:0]  running_slot;
    logic [1:0]  running_level;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mlfq_scoreboard sb = new();
    longint         cycles = 0;

    mlfq_thread_scheduler_core i_dut (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result('{status, result_valid, result_slot, switched,
                              running_valid, running_slot, running_level});
    end

    // Setup phase, access phase, then idle before the next write
    task write_quantum(logic [1:0] idx, logic [5:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {26'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.quantum[idx] = value;
        @(posedge clk);
    endtask

    task set_quanta(logic [5:0] qh, logic [5:0] qm, logic [5:0] ql);
        write_quantum(R_QHIGH, qh);
        write_quantum(R_QMID, qm);
        write_quantum(R_QLOW, ql);
    endtask

    // Hold start high until the request is taken; start stays high afterwards
    task send(sched_req_t r);
        start <= 1'b1;
        func <= r.func;
        thread_slot <= r.tslot;
        base_level <= r.blevel;
        cancel_deferred <= r.defer;
        event_num <= r.ev;
        wait_ticks <= r.wticks;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request(r);
    endtask

    task drain;
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_outcomes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function sched_req_t mk(logic [2:0] f, logic [3:0] ts, logic [1:0] bl,
                            logic df, logic [2:0] ev, logic [9:0] wt);
        sched_req_t r;
        r = '{f, ts, bl, df, ev, wt};
        return r;
    endfunction

    function sched_req_t random_request();
        sched_req_t r;
        int         roll;
        r = '{3'($urandom_range(7)), 4'($urandom_range(15)), 2'($urandom_range(3)),
              1'($urandom_range(1)), 3'($urandom_range(7)), 10'($urandom_range(1023))};
        roll = $urandom_range(99);
        if (roll < 20)      r.func = F_CREATE;
        else if (roll < 31) r.func = F_WAIT_EV;
        else if (roll < 45) r.func = F_SET_EV;
        else if (roll < 56) r.func = F_WAIT_TK;
        else if (roll < 80) r.func = F_TICK;
        else if (roll < 90) r.func = F_CANCEL;
        else if (roll < 98) r.func = F_TEST;
        else                r.func = F_UNUSED;
        // Keep most sleeps short so that sleepers come back within the run
        if ($urandom_range(99) < 96) r.wticks = 10'($urandom_range(6));
        return r;
    endfunction

    // Idle the sender for each cycle with a chance of gap_pct in a hundred
    task random_phase(int n, int gap_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(199) == 0) drain();
            else if ($urandom_range(99) < gap_pct) begin
                start <= 1'b0;
                @(posedge clk);
                while ($urandom_range(99) < gap_pct) @(posedge clk);
            end
            send(random_request());
        end
        drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_quanta(6'd1, 6'd63, 6'd2);

        // Idle corner cases first, then a short life cycle of a few threads
        send(mk(F_WAIT_EV, 4'd0, 2'd0, 1'b0, 3'd0, 10'd0));
        send(mk(F_TEST, 4'd0, 2'd0, 1'b0, 3'd0, 10'd0));
        send(mk(F_WAIT_TK, 4'd0, 2'd0, 1'b0, 3'd0, 10'd5));
        send(mk(F_TICK, 4'd0, 2'd0, 1'b0, 3'd0, 10'd0));
        send(mk(F_SET_EV, 4'd0, 2'd0, 1'b0, 3'd7, 10'd0));
        send(mk(F_CANCEL, 4'd15, 2'd0, 1'b0, 3'd0, 10'd0));
        send(mk(F_UNUSED, 4'd0, 2'd0, 1'b0, 3'd0, 10'd0));
        send(mk(F_CREATE, 4'd0, 2'd3, 1'b1, 3'd0, 10'd0));
        send(mk(F_CREATE, 4'd0, 2'd0, 1'b0, 3'd0, 10'd0));
        send(mk(F_CREATE, 4'd0, 2'd1, 1'b1, 3'd0, 10'd0));
        send(mk(F_CREATE, 4'd0, 2'd2, 1'b0, 3'd0, 10'd0));
        send(mk(F_TEST, 4'd0, 2'd0, 1'b0, 3'd0, 10'd0));
        send(mk(F_WAIT_EV, 4'd0, 2'd0, 1'b0, 3'd7, 10'd0));
        send(mk(F_TICK, 4'd0, 2'd0, 1'b0, 3'd0, 10'd0));
        send(mk(F_WAIT_TK, 4'd0, 2'd0, 1'b0, 3'd0, 10'd0));
        send(mk(F_WAIT_TK, 4'd0, 2'd0, 1'b0, 3'd0, 10'd1023));
        send(mk(F_TICK, 4'd0, 2'd0, 1'b0, 3'd0, 10'd0));
        send(mk(F_SET_EV, 4'd0, 2'd0, 1'b0, 3'd7, 10'd0));
        send(mk(F_CANCEL, 4'd0, 2'd0, 1'b0, 3'd0, 10'd0));
        send(mk(F_TEST, 4'd0, 2'd0, 1'b0, 3'd0, 10'd0));
        send(mk(F_CANCEL, 4'd1, 2'd0, 1'b0, 3'd0, 10'd0));
        send(mk(F_CANCEL, 4'd3, 2'd0, 1'b0, 3'd0, 10'd0));
        send(mk(F_TICK, 4'd0, 2'd0, 1'b0, 3'd0, 10'd0));
        drain();

        set_quanta(6'd63, 6'd63, 6'd63);
        random_phase(530, 14);
        set_quanta(6'd1, 6'd1, 6'd1);
        random_phase(530, 70);
        set_quanta(6'($urandom_range(1, 63)), 6'($urandom_range(1, 63)),
                   6'($urandom_range(1, 63)));
        random_phase(530, 0);

        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending_outcomes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
